>>> sv/mpct_pkg.sv
// Package for the mouse packet cursor tracker: packet slot codes,
// configuration register indexes, sync bit and reset positions.
// No dependencies.
package mpct_pkg;

	// Position of the next byte within a three-byte mouse packet
	typedef enum logic [1:0] {
		SLOT_HDR = 2'd0,
		SLOT_DX  = 2'd1,
		SLOT_DY  = 2'd2
	} slot_t;

	// Configuration register indexes
	localparam logic [0:0] CFG_MAX_POS_X = 1'b0;
	localparam logic [0:0] CFG_MAX_POS_Y = 1'b1;

	// Header byte always has this bit set; used to resync framing
	localparam logic [7:0] SYNC_MASK = 8'h08;

	// Reset values (fit the narrowest position width of 9 bits)
	localparam int RST_MAX_POS_X = 304;
	localparam int RST_MAX_POS_Y = 184;
	localparam int RST_CUR_X     = 160;
	localparam int RST_CUR_Y     = 100;

endpackage

>>> sv/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker top level: packet framing, cursor update,
// clamping and output register. Depends on mpct_pkg.
//
// Channel   | Dir | Handshake         | Payload
// ----------+-----+-------------------+------------------------------------------
// s_*       | in  | s_tvalid/s_tready | s_tdata = rx_byte, s_tuser = from_aux
// m_*       | out | m_tvalid/m_tready | m_tdata = {pad, pos_y, pos_x}
// cfg_*     | in  | cfg_we            | cfg_index selects max_pos_x / max_pos_y
//
// One byte per cycle is sustained unless a held result stalls the input stage:
// a byte lands in the input register (_s1) and is consumed from there by the
// slot/cursor logic, which loads the output register when a third packet byte
// completes a packet. m_tvalid rises at the edge that retires that byte.
// Reset clears framing, cursor and limits to their defaults; output is empty.
// A held result only stalls the input stage when the byte waiting in it
// would produce another result; header and X bytes keep flowing.
module mouse_packet_cursor_tracker #(
	parameter int POS_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,     // [7:0] rx_byte
	input  logic                s_tuser,     // [0] from_aux

	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [((2 * POS_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // pos_x, then pos_y, then zeros

	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [POS_BITS-1:0] cfg_data
);

	localparam int OUT_W = ((2 * POS_BITS + 7) / 8) * 8;
	localparam int PAD_W = OUT_W - 2 * POS_BITS;
	localparam int SUM_W = POS_BITS + 2;

	// Configuration registers
	logic [POS_BITS-1:0] max_pos_x_q, max_pos_y_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       aux_s1;

	// Framing and cursor state
	mpct_pkg::slot_t     byte_slot_q, slot_d;
	logic [7:0]          held_dx_q;
	logic [POS_BITS-1:0] cur_x_q, cur_y_q;

	// Output register
	logic                m_tvalid_q;
	logic [POS_BITS-1:0] out_x_q, out_y_q;

	logic                emit, out_free, done_s1;
	logic                load_dx;
	logic signed [SUM_W-1:0] nx, ny;
	logic [POS_BITS-1:0] clamp_x, clamp_y;

	// Write the limits; only indexes 0 and 1 exist.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_x_q <= POS_BITS'(mpct_pkg::RST_MAX_POS_X);
			max_pos_y_q <= POS_BITS'(mpct_pkg::RST_MAX_POS_Y);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpct_pkg::CFG_MAX_POS_X: max_pos_x_q <= cfg_data;
				mpct_pkg::CFG_MAX_POS_Y: max_pos_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Framing: advance the slot on aux bytes, drop unsynced headers.
	always_comb begin
		slot_d  = byte_slot_q;
		emit    = 1'b0;
		load_dx = 1'b0;
		if (valid_s1 && aux_s1) begin
			unique case (byte_slot_q)
				mpct_pkg::SLOT_DX: begin
					load_dx = 1'b1;
					slot_d  = mpct_pkg::SLOT_DY;
				end
				mpct_pkg::SLOT_DY: begin
					emit   = 1'b1;
					slot_d = mpct_pkg::SLOT_HDR;
				end
				default: begin
					// header, or an impossible slot code treated as header
					slot_d = ((byte_s1 & mpct_pkg::SYNC_MASK) != 8'h00)
						? mpct_pkg::SLOT_DX : mpct_pkg::SLOT_HDR;
				end
			endcase
		end
	end

	// Handshake between the input register and the output register
	assign out_free = !m_tvalid_q || m_tready;
	assign done_s1  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || done_s1;

	// Cursor arithmetic: x adds dx, y subtracts dy (screen y grows down)
	assign nx = $signed({2'b00, cur_x_q}) + SUM_W'($signed(held_dx_q));
	assign ny = $signed({2'b00, cur_y_q}) - SUM_W'($signed(byte_s1));

	always_comb begin
		if (nx < 0)
			clamp_x = '0;
		else if (nx > $signed({2'b00, max_pos_x_q}))
			clamp_x = max_pos_x_q;
		else
			clamp_x = nx[POS_BITS-1:0];

		if (ny < 0)
			clamp_y = '0;
		else if (ny > $signed({2'b00, max_pos_y_q}))
			clamp_y = max_pos_y_q;
		else
			clamp_y = ny[POS_BITS-1:0];
	end

	// Input register: hold a byte until the processing stage retires it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			aux_s1  <= s_tuser;
		end
	end

	// Packet state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_slot_q <= mpct_pkg::SLOT_HDR;
			held_dx_q   <= 8'h00;
			cur_x_q     <= POS_BITS'(mpct_pkg::RST_CUR_X);
			cur_y_q     <= POS_BITS'(mpct_pkg::RST_CUR_Y);
		end else if (done_s1) begin
			byte_slot_q <= slot_d;
			if (load_dx)
				held_dx_q <= byte_s1;
			if (emit) begin
				cur_x_q <= clamp_x;
				cur_y_q <= clamp_y;
			end
		end
	end

	// Output register: load on a completed packet, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done_s1 && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && emit) begin
			out_x_q <= clamp_x;
			out_y_q <= clamp_y;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_y_q, out_x_q};

	// A result appears only after a Y delta byte was retired.
	a_emit_from_dy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(valid_s1 && aux_s1 && byte_slot_q == mpct_pkg::SLOT_DY))
		else $error("result without a completed packet");

	// Held result matches the tracked cursor.
	a_out_tracks_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_x_q == cur_x_q && out_y_q == cur_y_q))
		else $error("output payload differs from cursor");

	// A freshly updated cursor lies within the limits.
	a_cursor_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && emit && !cfg_we) |=> (cur_x_q <= max_pos_x_q && cur_y_q <= max_pos_y_q))
		else $error("cursor outside limits after packet");

	// With the output empty the input never stalls.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with empty output");

endmodule
